// ----- hw/rtl/owbm_pkg.sv -----
// Package for the one-wire bus master: beat types, configuration registers,
// phase encoding and timing helpers. It depends on nothing else.
package owbm_pkg;

  localparam int BitsPerByte = 8;
  localparam int BitCntW     = $clog2(BitsPerByte + 1);
  localparam int TimeW       = 10;
  localparam int CfgIdxW     = 4;

  // Command codes carried in the kind field of an input beat.
  localparam logic [1:0] KindTick  = 2'd0;
  localparam logic [1:0] KindReset = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;
  localparam logic [1:0] KindRead  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgResetLow   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgPresSample = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgResetTail  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgSlotLead   = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgReadDelay  = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgReadTail   = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgWriteHold  = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgRecovery   = 4'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_byte;
    logic       line_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       device_present;
    logic       line_shorted;
    logic       bus_error;
  } owbm_out_t;

  typedef struct packed {
    logic [TimeW-1:0] reset_low_time;
    logic [TimeW-1:0] presence_sample_time;
    logic [TimeW-1:0] reset_tail_time;
    logic [TimeW-1:0] slot_lead_time;
    logic [TimeW-1:0] read_sample_delay;
    logic [TimeW-1:0] read_tail_time;
    logic [TimeW-1:0] write_hold_time;
    logic [TimeW-1:0] recovery_time;
  } owbm_cfg_t;

  localparam owbm_cfg_t CfgDefault = '{
    reset_low_time:       10'd470,
    presence_sample_time: 10'd60,
    reset_tail_time:      10'd410,
    slot_lead_time:       10'd5,
    read_sample_delay:    10'd5,
    read_tail_time:       10'd50,
    write_hold_time:      10'd55,
    recovery_time:        10'd5
  };

  typedef enum logic [13:0] {
    PhIdle      = 14'b00000000000001,
    PhRstLow    = 14'b00000000000010,
    PhRstWait   = 14'b00000000000100,
    PhRstTail   = 14'b00000000001000,
    PhRstRecov  = 14'b00000000010000,
    PhWLead     = 14'b00000000100000,
    PhWHold     = 14'b00000001000000,
    PhWRecov    = 14'b00000010000000,
    PhRLead     = 14'b00000100000000,
    PhRDelay    = 14'b00001000000000,
    PhRSample   = 14'b00010000000000,
    PhRTail     = 14'b00100000000000,
    PhRRecov    = 14'b01000000000000,
    PhByteRecov = 14'b10000000000000
  } owbm_phase_e;

  // A zero in a register whose minimum is one counts as one.
  function automatic logic [TimeW-1:0] at_least_one(input logic [TimeW-1:0] v);
    at_least_one = (v == '0) ? TimeW'(1) : v;
  endfunction

  // Number of microseconds spent in a phase; zero means the phase is skipped.
  function automatic logic [TimeW-1:0] phase_len(input owbm_phase_e ph,
                                                 input owbm_cfg_t   cfg);
    logic [TimeW-1:0] len;
    len = '0;
    unique case (ph)
      PhRstLow:               len = at_least_one(cfg.reset_low_time);
      PhRstWait:              len = at_least_one(cfg.presence_sample_time);
      PhRstTail:              len = at_least_one(cfg.reset_tail_time);
      PhWLead, PhRLead:       len = at_least_one(cfg.slot_lead_time);
      PhWHold:                len = at_least_one(cfg.write_hold_time);
      PhRDelay:               len = cfg.read_sample_delay;
      PhRSample:              len = TimeW'(1);
      PhRTail:                len = cfg.read_tail_time;
      PhRstRecov, PhWRecov,
      PhRRecov, PhByteRecov:  len = cfg.recovery_time;
      default:                len = '0;
    endcase
    phase_len = len;
  endfunction

endpackage

// ----- hw/rtl/one_wire_bus_master.sv -----
// One-wire bus master, top level: command sequencer, timers and result register.
// Depends on owbm_pkg.
//
// Each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle, held back only while a result waits
// in the output register and the downstream side is not ready.
// Reset (rst_ni low, asynchronous): the bus goes idle, all flags, counters and
// the read byte clear, and the timing registers return to their defaults.
module one_wire_bus_master (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  owbm_pkg::owbm_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output owbm_pkg::owbm_out_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [owbm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [owbm_pkg::TimeW-1:0]   cfg_data_i
);
  import owbm_pkg::*;

  // Each input beat is one microsecond of bus time. The whole tick, from a
  // possible command start through the timer step and phase advance, is
  // evaluated in one pass and lands in the result register.

  owbm_cfg_t cfg_q;

  owbm_phase_e          phase_q, phase_d;
  logic [TimeW-1:0]     timer_q, timer_d;
  logic [BitCntW-1:0]   bits_q, bits_d;
  logic [7:0]           shift_q, shift_d;
  logic                 pres_q, pres_d;
  logic                 short_q, short_d;
  logic                 err_q, err_d;
  logic [7:0]           rres_q, rres_d;

  logic                 out_valid_q;
  owbm_out_t            out_q, res_d;
  logic                 in_acc;

  // The result register frees up in the same cycle that it is drained.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgDefault;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgResetLow:   cfg_q.reset_low_time       <= cfg_data_i;
        CfgPresSample: cfg_q.presence_sample_time <= cfg_data_i;
        CfgResetTail:  cfg_q.reset_tail_time      <= cfg_data_i;
        CfgSlotLead:   cfg_q.slot_lead_time       <= cfg_data_i;
        CfgReadDelay:  cfg_q.read_sample_delay    <= cfg_data_i;
        CfgReadTail:   cfg_q.read_tail_time       <= cfg_data_i;
        CfgWriteHold:  cfg_q.write_hold_time      <= cfg_data_i;
        CfgRecovery:   cfg_q.recovery_time        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One microsecond tick. Phases whose length is zero are skipped in the same
  // tick, so the successor choice below already folds the skip chains.
  always_comb begin
    owbm_phase_e ph, nph, byte_end;
    logic        rec_zero;
    logic        busy, drv, done;

    ph       = phase_q;
    nph      = phase_q;
    timer_d  = timer_q;
    bits_d   = bits_q;
    shift_d  = shift_q;
    pres_d   = pres_q;
    short_d  = short_q;
    err_d    = err_q;
    rres_d   = rres_q;
    busy     = 1'b0;
    drv      = 1'b0;
    done     = 1'b0;
    rec_zero = (cfg_q.recovery_time == '0);
    byte_end = rec_zero ? PhIdle : PhByteRecov;

    // A command only starts from idle, and its first tick is this one.
    if (ph == PhIdle && in_data_i.kind != KindTick) begin
      bits_d = BitCntW'(BitsPerByte);
      unique case (in_data_i.kind)
        KindReset: begin
          err_d = 1'b0;
          ph    = PhRstLow;
        end
        KindWrite: begin
          shift_d = in_data_i.write_byte;
          ph      = PhWLead;
        end
        default: begin
          shift_d = '0;
          ph      = PhRLead;
        end
      endcase
      timer_d = phase_len(ph, cfg_q);
    end

    nph = ph;
    if (ph != PhIdle) begin
      busy = 1'b1;
      if (ph == PhRstLow || ph == PhWLead || ph == PhRLead) begin
        drv = 1'b1;
      end else if (ph == PhWHold) begin
        drv = !shift_d[0];
      end

      // Presence and short checks fall on the last tick of their phase.
      if (ph == PhRstWait && timer_d == TimeW'(1)) begin
        pres_d = !in_data_i.line_level;
      end else if (ph == PhRstTail && timer_d == TimeW'(1)) begin
        short_d = !in_data_i.line_level;
        err_d   = !in_data_i.line_level || !pres_d;
      end else if (ph == PhRSample) begin
        shift_d = {in_data_i.line_level, shift_d[7:1]};
      end

      if (timer_d != '0) begin
        timer_d = timer_d - TimeW'(1);
      end

      if (timer_d == '0) begin
        unique case (ph)
          PhRstLow:  nph = PhRstWait;
          PhRstWait: nph = PhRstTail;
          PhRstTail: nph = rec_zero ? PhIdle : PhRstRecov;
          PhWLead:   nph = PhWHold;
          PhRLead:   nph = (cfg_q.read_sample_delay == '0) ? PhRSample : PhRDelay;
          PhRDelay:  nph = PhRSample;
          PhWHold, PhWRecov: begin
            if (ph == PhWHold && !rec_zero) begin
              nph = PhWRecov;
            end else begin
              // End of a write slot: move to the next bit.
              shift_d = {1'b0, shift_d[7:1]};
              if (bits_d != '0) begin
                bits_d = bits_d - BitCntW'(1);
              end
              nph = (bits_d != '0) ? PhWLead : byte_end;
            end
          end
          PhRSample, PhRTail, PhRRecov: begin
            if (ph == PhRSample && cfg_q.read_tail_time != '0) begin
              nph = PhRTail;
            end else if (ph != PhRRecov && !rec_zero) begin
              nph = PhRRecov;
            end else begin
              // End of a read slot: the byte is published after the last bit.
              if (bits_d != '0) begin
                bits_d = bits_d - BitCntW'(1);
              end
              if (bits_d != '0) begin
                nph = PhRLead;
              end else begin
                rres_d = shift_d;
                nph    = byte_end;
              end
            end
          end
          default:   nph = PhIdle;
        endcase
        timer_d = phase_len(nph, cfg_q);
        done    = (nph == PhIdle);
      end
    end

    phase_d              = nph;
    res_d.drive_low      = drv;
    res_d.busy_res       = busy;
    res_d.done_res       = done;
    res_d.read_byte      = rres_d;
    res_d.device_present = pres_d;
    res_d.line_shorted   = short_d;
    res_d.bus_error      = err_d;
  end

  // Sequencer state advances once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      timer_q <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      short_q <= 1'b0;
      err_q   <= 1'b0;
      rres_q  <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      short_q <= short_d;
      err_q   <= err_d;
      rres_q  <= rres_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res_d;
    end
  end

endmodule

// ----- hw/rtl/owbm_checker.sv -----
// Port-level checks for the one-wire bus master and the bind that attaches them.
// Depends on owbm_pkg and one_wire_bus_master.
module owbm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input owbm_pkg::owbm_out_t          out_data_o
);
  import owbm_pkg::*;

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // An empty result register never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // The line is only pulled low, and an operation only ends, while busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.drive_low || out_data_o.done_res) |-> out_data_o.busy_res)
    else $error("drive or done without busy");

  // The error flag is only ever set from a missing presence pulse or a short.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bus_error |->
      (out_data_o.line_shorted || !out_data_o.device_present))
    else $error("bus error without short or missing presence");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
